### rtl/integer_to_roman_numeral_unit_defines.svh
// Assertion macros for the integer to Roman numeral unit.
// Used by the port-level checker; needs clk and arst_n in scope.
`ifndef INTEGER_TO_ROMAN_NUMERAL_UNIT_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2R_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/i2r_pkg.sv
// Shared constants, microcode word type and microcode ROM for the
// integer to Roman numeral unit. No dependencies.
package i2r_pkg;

	localparam int unsigned VALUE_W = 12;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned WEIGHT_W = 10;
	localparam int unsigned PC_W    = 5;

	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

	localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
	localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
	localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
	localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
	localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

	localparam logic [PC_W-1:0] STEP_FIRST = 5'd0;
	localparam logic [PC_W-1:0] STEP_EMPTY = 5'd19;

	typedef enum logic [1:0] {
		OP_TEST,   // rem >= weight ? emit ch : jump to jmp
		OP_EMIT,   // emit ch, subtract weight, jump to jmp
		OP_EMPTY   // emit the empty marker and finish
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic                pair;    // TEST hit starts a two-letter symbol
		logic [WEIGHT_W-1:0] weight;
		logic [CHAR_W-1:0]   ch;
		logic [PC_W-1:0]     jmp;
	} ucode_t;

	// Program: one TEST per table entry, plus an EMIT for the second
	// letter of CM, CD, XC, XL, IX and IV which also does the subtract.
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			5'd0:    w = '{OP_TEST, 1'b0, 10'd1000, CH_M, 5'd1};
			5'd1:    w = '{OP_TEST, 1'b1, 10'd900,  CH_C, 5'd3};
			5'd2:    w = '{OP_EMIT, 1'b0, 10'd900,  CH_M, 5'd1};
			5'd3:    w = '{OP_TEST, 1'b0, 10'd500,  CH_D, 5'd4};
			5'd4:    w = '{OP_TEST, 1'b1, 10'd400,  CH_C, 5'd6};
			5'd5:    w = '{OP_EMIT, 1'b0, 10'd400,  CH_D, 5'd4};
			5'd6:    w = '{OP_TEST, 1'b0, 10'd100,  CH_C, 5'd7};
			5'd7:    w = '{OP_TEST, 1'b1, 10'd90,   CH_X, 5'd9};
			5'd8:    w = '{OP_EMIT, 1'b0, 10'd90,   CH_C, 5'd7};
			5'd9:    w = '{OP_TEST, 1'b0, 10'd50,   CH_L, 5'd10};
			5'd10:   w = '{OP_TEST, 1'b1, 10'd40,   CH_X, 5'd12};
			5'd11:   w = '{OP_EMIT, 1'b0, 10'd40,   CH_L, 5'd10};
			5'd12:   w = '{OP_TEST, 1'b0, 10'd10,   CH_X, 5'd13};
			5'd13:   w = '{OP_TEST, 1'b1, 10'd9,    CH_I, 5'd15};
			5'd14:   w = '{OP_EMIT, 1'b0, 10'd9,    CH_X, 5'd13};
			5'd15:   w = '{OP_TEST, 1'b0, 10'd5,    CH_V, 5'd16};
			5'd16:   w = '{OP_TEST, 1'b1, 10'd4,    CH_I, 5'd18};
			5'd17:   w = '{OP_EMIT, 1'b0, 10'd4,    CH_V, 5'd16};
			5'd18:   w = '{OP_TEST, 1'b0, 10'd1,    CH_I, 5'd18};
			default: w = '{OP_EMPTY, 1'b0, 10'd0,   CH_NONE, STEP_FIRST};
		endcase
		return w;
	endfunction

endpackage

### rtl/integer_to_roman_numeral_unit.sv
// Integer to Roman numeral unit: takes a 12-bit value per request and returns
// its Roman numeral one ASCII character per output request, is_last on the
// final one. Zero and values above 3999 give a single empty result
// (out_of_range set for the latter). Once a request is taken, a microcoded
// sequencer steps through a 20-word ROM, one word a cycle while the output
// register can take a result. A step either emits a character or falls
// through a table entry that no longer fits. The longest numeral, 3888, has
// 15 characters and 12 fall-throughs. A result that is stalled downstream
// holds the sequencer until the output register can take a result again.
// in_stall stays high until the last character has been loaded into the
// output register; the output register lets the next request in while that
// character is still waiting downstream.
module integer_to_roman_numeral_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [i2r_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [i2r_pkg::CHAR_W-1:0]  symbol_char,
	output logic                        is_last,
	output logic                        is_empty,
	output logic                        out_of_range
);
	import i2r_pkg::*;

	// sequencer state
	logic                busy_q;
	logic [PC_W-1:0]     pc_q;
	logic [VALUE_W-1:0]  rem_q;
	logic                oor_q;

	// output register
	logic                out_valid_q;
	logic [CHAR_W-1:0]   symbol_char_q;
	logic                is_last_q;
	logic                is_empty_q;
	logic                out_of_range_q;

	ucode_t              uw;
	logic                in_take;
	logic                out_free;
	logic                step_en;
	logic                hit;
	logic [VALUE_W-1:0]  diff;
	logic                emit;
	logic                emit_last;
	logic                emit_empty;
	logic [CHAR_W-1:0]   emit_ch;
	logic [PC_W-1:0]     pc_nxt;
	logic [VALUE_W-1:0]  rem_nxt;
	logic                in_zero;
	logic                in_oor;

	assign in_stall = busy_q;
	assign in_take  = in_valid & ~busy_q;
	assign in_zero  = (value == '0);
	assign in_oor   = (value > MAX_VALUE);

	// Sequencer may step whenever the output register can take a result.
	assign out_free = ~out_valid_q | ~out_stall;
	assign step_en  = busy_q & out_free;

	assign uw   = ucode(pc_q);
	assign hit  = (rem_q >= {{(VALUE_W-WEIGHT_W){1'b0}}, uw.weight});
	assign diff = rem_q - {{(VALUE_W-WEIGHT_W){1'b0}}, uw.weight};

	// Decode of the current control word.
	always_comb begin
		emit       = 1'b0;
		emit_last  = 1'b0;
		emit_empty = 1'b0;
		emit_ch    = uw.ch;
		pc_nxt     = pc_q;
		rem_nxt    = rem_q;
		case (uw.op)
			OP_TEST: begin
				if (hit) begin
					emit = 1'b1;
					if (uw.pair) begin
						// first letter of a pair; the EMIT word subtracts
						pc_nxt = pc_q + 5'd1;
					end else begin
						rem_nxt   = diff;
						emit_last = (diff == '0);
					end
				end else begin
					pc_nxt = uw.jmp;
				end
			end
			OP_EMIT: begin
				emit      = 1'b1;
				rem_nxt   = diff;
				pc_nxt    = uw.jmp;
				emit_last = (diff == '0);
			end
			OP_EMPTY: begin
				emit       = 1'b1;
				emit_last  = 1'b1;
				emit_empty = 1'b1;
				emit_ch    = CH_NONE;
			end
			default: begin
				emit      = 1'b1;
				emit_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_FIRST;
		end else if (in_take) begin
			busy_q <= 1'b1;
			pc_q   <= (in_zero | in_oor) ? STEP_EMPTY : STEP_FIRST;
		end else if (step_en) begin
			pc_q <= pc_nxt;
			if (emit && emit_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and range flag: payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			rem_q <= value;
			oor_q <= in_oor;
		end else if (step_en) begin
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			symbol_char_q  <= emit_ch;
			is_last_q      <= emit_last;
			is_empty_q     <= emit_empty;
			out_of_range_q <= emit_empty & oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol_char  = symbol_char_q;
	assign is_last      = is_last_q;
	assign is_empty     = is_empty_q;
	assign out_of_range = out_of_range_q;

endmodule

### rtl/i2r_checker.sv
// Port-level checker for integer_to_roman_numeral_unit, bound to the top level.
// Depends on i2r_pkg and integer_to_roman_numeral_unit_defines.svh.
`include "integer_to_roman_numeral_unit_defines.svh"

module i2r_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [i2r_pkg::VALUE_W-1:0] value,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [i2r_pkg::CHAR_W-1:0]  symbol_char,
	input logic                        is_last,
	input logic                        is_empty,
	input logic                        out_of_range
);
	import i2r_pkg::*;

	// a held result keeps its character
	`I2R_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(symbol_char), "result changed while stalled")

	// one request at a time: taking one closes the input
	`I2R_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input open right after a request")

	// an empty result is a single, last one with no character
	`I2R_ASSERT_NOW(a_empty_shape, out_valid && is_empty, is_last && symbol_char == CH_NONE, "bad empty result")

	`I2R_ASSERT_NOW(a_oor_empty, out_valid && out_of_range, is_empty, "out of range without empty")

	// character results carry only numeral letters
	`I2R_ASSERT_NOW(a_char_legal, out_valid && !is_empty, symbol_char == CH_I || symbol_char == CH_V || symbol_char == CH_X || symbol_char == CH_L || symbol_char == CH_C || symbol_char == CH_D || symbol_char == CH_M, "illegal character")

endmodule

bind integer_to_roman_numeral_unit i2r_checker u_i2r_checker (.*);
